FILE: rtl/gaops_pkg.sv
// Shared constants, types and helper functions of the grouped aligned offset prefix sum.
package gaops_pkg;

   // Array geometry and alignment of the region offsets.
   localparam int ROWS    = 8;
   localparam int COLUMNS = 256;
   localparam int ALIGN   = 32;

   // Field widths of the item, result and register ports.
   localparam int DATA_W   = 32;
   localparam int ACTION_W = 2;
   localparam int ROW_W    = 3;
   localparam int COL_W    = 8;
   localparam int GS_W     = 9;
   localparam int OWN_W    = 3;
   localparam int CSR_AW   = 3;

   // Index widths of the stores.
   localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int CELL_AW = (ROWS * COLUMNS > 1) ? $clog2(ROWS * COLUMNS) : 1;
   localparam int SPAN_W  = COL_AW + GS_W + 1;

   localparam logic [DATA_W-1:0] ALIGN_W = DATA_W'(ALIGN);

   // Action codes of an input item.
   localparam logic [ACTION_W-1:0] ACT_LOAD     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FINALIZE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY    = 2'd2;

   // Result kinds.
   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Register indexes, decoded from address bit 2.
   localparam logic REG_GROUP_SIZE = 1'b0;
   localparam logic REG_OWN_ROW    = 1'b1;

   localparam logic [GS_W-1:0]  GROUP_SIZE_RESET = 9'd8;
   localparam logic [OWN_W-1:0] OWN_ROW_RESET    = 3'd0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic rd_en;
      logic ofs;
   } dp_cmd_type;

   // Sweep status from the datapath to the controller.
   typedef struct packed {
      logic last_row;
      logic last_col;
   } dp_stat_type;

   // Round up to a multiple of ALIGN with 32-bit wrap.
   function automatic logic [DATA_W-1:0] round_up(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] biased;
      biased = v + (ALIGN_W - DATA_W'(1));
      return (biased / ALIGN_W) * ALIGN_W;
   endfunction

   // Linear cell address of (row, column) in a row-major store.
   function automatic logic [CELL_AW-1:0] cell_addr(input logic [31:0] r,
                                                    input logic [31:0] c);
      logic [31:0] lin;
      lin = r * 32'(COLUMNS) + c;
      return lin[CELL_AW-1:0];
   endfunction

   function automatic logic row_ok(input logic [31:0] r);
      return r < 32'(ROWS);
   endfunction

   function automatic logic col_ok(input logic [31:0] c);
      return c < 32'(COLUMNS);
   endfunction

endpackage

FILE: rtl/grouped_aligned_offset_prefix_sum.sv
// Load: written at the accepting edge; one load per cycle while not busy. Query: answered
// in the cycle after acceptance, one query per cycle while not busy, from registered
// reads of the result stores. Finalize: busy while the single read port of the count store
// visits each column twice; the acknowledgment is in the last busy cycle.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset (synchronous) idles the controller and restores register defaults; stores keep data.
module grouped_aligned_offset_prefix_sum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gaops_pkg::ACTION_W-1:0]    req_action,
   input  logic [gaops_pkg::ROW_W-1:0]       req_row,
   input  logic [gaops_pkg::COL_W-1:0]       req_col,
   input  logic [gaops_pkg::DATA_W-1:0]      req_count,
   output logic                              rsp_strobe,
   output logic                              rsp_kind,
   output logic [gaops_pkg::DATA_W-1:0]      rsp_total,
   output logic [gaops_pkg::DATA_W-1:0]      rsp_region,
   output logic [gaops_pkg::DATA_W-1:0]      rsp_row_offset,
   output logic [gaops_pkg::DATA_W-1:0]      rsp_own_offset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gaops_pkg::CSR_AW-1:0]      paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic                         accept;
   logic                         ack;
   logic                         query_valid;
   logic [gaops_pkg::GS_W-1:0]   group_size;
   logic [gaops_pkg::OWN_W-1:0]  own_row;
   gaops_pkg::dp_cmd_type        cmd;
   gaops_pkg::dp_stat_type       stat;

   assign accept = start && !busy;

   gaops_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .group_size (group_size),
      .own_row    (own_row)
   );

   gaops_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd),
      .ack    (ack)
   );

   gaops_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .row         (req_row),
      .col         (req_col),
      .count       (req_count),
      .group_size  (group_size),
      .own_row     (own_row),
      .cmd         (cmd),
      .stat        (stat),
      .query_valid (query_valid),
      .total       (rsp_total),
      .region      (rsp_region),
      .row_offset  (rsp_row_offset),
      .own_offset  (rsp_own_offset)
   );

   // Result channel: query answers from the datapath, finalize acknowledgment from control.
   assign rsp_strobe = query_valid || ack;
   assign rsp_kind   = query_valid ? gaops_pkg::KIND_QUERY : gaops_pkg::KIND_ACK;

   // A query answer and a finalize acknowledgment never share a cycle.
   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      !(query_valid && ack))
      else $error("query answer and finalize acknowledgment in the same cycle");

   // An accepted finalize makes the block busy in the next cycle.
   a_fin_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == gaops_pkg::ACT_FINALIZE)) |=> busy)
      else $error("finalize accepted without going busy");

   // Busy ends only right after the acknowledgment.
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> $past(ack))
      else $error("busy dropped without a finalize acknowledgment");

   // An accepted query is answered in the next cycle.
   a_query_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == gaops_pkg::ACT_QUERY)) |=>
         (rsp_strobe && (rsp_kind == gaops_pkg::KIND_QUERY)))
      else $error("query not answered one cycle after acceptance");

endmodule

FILE: rtl/gaops_csr.sv
module gaops_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gaops_pkg::CSR_AW-1:0]      paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output logic [gaops_pkg::GS_W-1:0]        group_size,
   output logic [gaops_pkg::OWN_W-1:0]       own_row
);

   logic [gaops_pkg::GS_W-1:0]  group_size_ff;
   logic [gaops_pkg::OWN_W-1:0] own_row_ff;
   logic                        wr_en;
   logic                        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[2];

   // Register writes at the access phase of a write transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= gaops_pkg::GROUP_SIZE_RESET;
         own_row_ff    <= gaops_pkg::OWN_ROW_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            gaops_pkg::REG_GROUP_SIZE: group_size_ff <= pwdata[gaops_pkg::GS_W-1:0];
            gaops_pkg::REG_OWN_ROW:    own_row_ff    <= pwdata[gaops_pkg::OWN_W-1:0];
            default: ;
         endcase
      end
   end

   // Read data mux.
   always_comb begin
      case (reg_idx)
         gaops_pkg::REG_GROUP_SIZE: prdata = 32'(group_size_ff);
         gaops_pkg::REG_OWN_ROW:    prdata = 32'(own_row_ff);
         default:                   prdata = '0;
      endcase
   end

   assign group_size = group_size_ff;
   assign own_row    = own_row_ff;

endmodule

FILE: rtl/gaops_ctrl.sv
module gaops_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gaops_pkg::ACTION_W-1:0]    action,
   input  gaops_pkg::dp_stat_type            stat,
   output logic                              busy,
   output gaops_pkg::dp_cmd_type             cmd,
   output logic                              ack
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SUM   = 6'b000010,
      S_WAIT  = 6'b000100,
      S_OFS   = 6'b001000,
      S_DRAIN = 6'b010000,
      S_ACK   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // Per column: a summing sweep over the rows, a wait state for the region to settle,
   // then an offset sweep over the rows; after the last column, drain, then acknowledge.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ack      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && (action == gaops_pkg::ACT_FINALIZE)) begin
               cmd.clear = 1'b1;
               state_in  = S_SUM;
            end
         end
         S_SUM: begin
            cmd.rd_en = 1'b1;
            if (stat.last_row) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_OFS;
         end
         S_OFS: begin
            cmd.rd_en = 1'b1;
            cmd.ofs   = 1'b1;
            if (stat.last_row) begin
               state_in = stat.last_col ? S_DRAIN : S_SUM;
            end
         end
         S_DRAIN: begin
            state_in = S_ACK;
         end
         S_ACK: begin
            ack      = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/gaops_dp.sv
module gaops_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [gaops_pkg::ACTION_W-1:0]    action,
   input  logic [gaops_pkg::ROW_W-1:0]       row,
   input  logic [gaops_pkg::COL_W-1:0]       col,
   input  logic [gaops_pkg::DATA_W-1:0]      count,
   input  logic [gaops_pkg::GS_W-1:0]        group_size,
   input  logic [gaops_pkg::OWN_W-1:0]       own_row,
   input  gaops_pkg::dp_cmd_type             cmd,
   output gaops_pkg::dp_stat_type            stat,
   output logic                              query_valid,
   output logic [gaops_pkg::DATA_W-1:0]      total,
   output logic [gaops_pkg::DATA_W-1:0]      region,
   output logic [gaops_pkg::DATA_W-1:0]      row_offset,
   output logic [gaops_pkg::DATA_W-1:0]      own_offset
);

   localparam int RA = gaops_pkg::ROW_AW;
   localparam int CA = gaops_pkg::COL_AW;
   localparam int DW = gaops_pkg::DATA_W;

   // Stores.
   logic [DW-1:0] count_mem  [gaops_pkg::ROWS * gaops_pkg::COLUMNS];
   logic [DW-1:0] offset_mem [gaops_pkg::ROWS * gaops_pkg::COLUMNS];
   logic [DW-1:0] total_mem  [gaops_pkg::COLUMNS];
   logic [DW-1:0] region_mem [gaops_pkg::COLUMNS];

   // Sweep counters.
   logic [RA-1:0] row_cnt_ff, row_cnt_in;
   logic [CA-1:0] col_cnt_ff, col_cnt_in;

   // Sweep read stage.
   logic          rd_v_ff;
   logic          rd_ofs_ff;
   logic [RA-1:0] rd_row_ff;
   logic [CA-1:0] rd_col_ff;
   logic [DW-1:0] cnt_rd_ff;
   logic          rd_first;
   logic          rd_last;

   // Column sum, region and group prefix stages.
   logic [DW-1:0]                   sum_ff, sum_in;
   logic                            tot_v_ff;
   logic [DW-1:0]                   total_ff;
   logic [CA-1:0]                   tot_col_ff;
   logic [gaops_pkg::SPAN_W-1:0]    span;
   logic                            whole;
   logic [DW-1:0]                   region_new;
   logic [DW-1:0]                   region_ff;
   logic [DW-1:0]                   rnd_ff;
   logic                            grp_end_ff;
   logic                            upd_v_ff;
   logic [DW-1:0]                   prefix_ff;
   logic [gaops_pkg::GS_W-1:0]      pos_ff;

   // Offset sweep accumulator.
   logic [DW-1:0] ofs_base;
   logic [DW-1:0] oacc_ff;

   // Query read stage.
   logic          q_go;
   logic          load_go;
   logic          q_v_ff;
   logic          q_col_ok_ff;
   logic          q_row_ok_ff;
   logic          q_own_ok_ff;
   logic [DW-1:0] tot_rd_ff;
   logic [DW-1:0] reg_rd_ff;
   logic [DW-1:0] ofs_row_rd_ff;
   logic [DW-1:0] ofs_own_rd_ff;
   logic [DW-1:0] span_end;

   assign stat.last_row = (row_cnt_ff == RA'(gaops_pkg::ROWS - 1));
   assign stat.last_col = (col_cnt_ff == CA'(gaops_pkg::COLUMNS - 1));

   // Row counter runs inside a column; the column steps after its offset sweep.
   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      if (cmd.clear) begin
         row_cnt_in = '0;
         col_cnt_in = '0;
      end else if (cmd.rd_en) begin
         if (stat.last_row) begin
            row_cnt_in = '0;
            if (cmd.ofs) begin
               col_cnt_in = stat.last_col ? '0 : col_cnt_ff + CA'(1);
            end
         end else begin
            row_cnt_in = row_cnt_ff + RA'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
      end
   end

   assign load_go = accept && (action == gaops_pkg::ACT_LOAD)
                    && gaops_pkg::row_ok(32'(row)) && gaops_pkg::col_ok(32'(col));
   assign q_go    = accept && (action == gaops_pkg::ACT_QUERY);

   // Count store: loads write, the finalize sweep reads.
   always_ff @(posedge clock) begin
      if (load_go) begin
         count_mem[gaops_pkg::cell_addr(32'(row), 32'(col))] <= count;
      end
      if (cmd.rd_en) begin
         cnt_rd_ff <= count_mem[gaops_pkg::cell_addr(32'(row_cnt_ff), 32'(col_cnt_ff))];
      end
   end

   // Tag of the sweep read that is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.rd_en;
      end
      rd_ofs_ff <= cmd.ofs;
      rd_row_ff <= row_cnt_ff;
      rd_col_ff <= col_cnt_ff;
   end

   assign rd_first = (rd_row_ff == '0);
   assign rd_last  = (rd_row_ff == RA'(gaops_pkg::ROWS - 1));

   // Column total accumulates over the summing sweep.
   assign sum_in = (rd_first ? '0 : sum_ff) + cnt_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_v_ff <= 1'b0;
      end else begin
         tot_v_ff <= rd_v_ff && !rd_ofs_ff && rd_last;
      end
      if (rd_v_ff && !rd_ofs_ff) begin
         sum_ff <= sum_in;
         if (rd_last) begin
            total_ff   <= sum_in;
            tot_col_ff <= rd_col_ff;
         end
      end
   end

   // A column lies in a whole group when its group ends inside the array.
   assign span       = gaops_pkg::SPAN_W'(tot_col_ff) - gaops_pkg::SPAN_W'(pos_ff)
                       + gaops_pkg::SPAN_W'(group_size);
   assign whole      = (group_size != '0) && (span <= gaops_pkg::SPAN_W'(gaops_pkg::COLUMNS));
   assign region_new = whole ? prefix_ff : total_ff;

   // Region stage: store total and region, round the total for the group prefix.
   always_ff @(posedge clock) begin
      if (reset) begin
         upd_v_ff <= 1'b0;
      end else begin
         upd_v_ff <= tot_v_ff;
      end
      if (tot_v_ff) begin
         region_ff             <= region_new;
         total_mem[tot_col_ff]  <= total_ff;
         region_mem[tot_col_ff] <= region_new;
         rnd_ff                <= gaops_pkg::round_up(total_ff);
         grp_end_ff            <= ((pos_ff + gaops_pkg::GS_W'(1)) == group_size);
      end
   end

   // Group prefix and position within the group.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         prefix_ff <= '0;
         pos_ff    <= '0;
      end else if (upd_v_ff) begin
         prefix_ff <= grp_end_ff ? '0 : prefix_ff + rnd_ff;
         pos_ff    <= grp_end_ff ? '0 : pos_ff + gaops_pkg::GS_W'(1);
      end
   end

   // Offset sweep: each row gets the region plus the counts of the rows above it.
   assign ofs_base = rd_first ? region_ff : oacc_ff;

   always_ff @(posedge clock) begin
      if (rd_v_ff && rd_ofs_ff) begin
         offset_mem[gaops_pkg::cell_addr(32'(rd_row_ff), 32'(rd_col_ff))] <= ofs_base;
         oacc_ff <= ofs_base + cnt_rd_ff;
      end
   end

   // Query reads, registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff <= 1'b0;
      end else begin
         q_v_ff <= q_go;
      end
      if (q_go) begin
         tot_rd_ff     <= total_mem[CA'(col)];
         reg_rd_ff     <= region_mem[CA'(col)];
         ofs_row_rd_ff <= offset_mem[gaops_pkg::cell_addr(32'(row), 32'(col))];
         ofs_own_rd_ff <= offset_mem[gaops_pkg::cell_addr(32'(own_row), 32'(col))];
         q_col_ok_ff   <= gaops_pkg::col_ok(32'(col));
         q_row_ok_ff   <= gaops_pkg::row_ok(32'(row));
         q_own_ok_ff   <= gaops_pkg::row_ok(32'(own_row));
      end
   end

   // Answer fields; a row past the last one reports the end of the column's span.
   assign span_end    = reg_rd_ff + tot_rd_ff;
   assign query_valid = q_v_ff;

   always_comb begin
      total      = '0;
      region     = '0;
      row_offset = '0;
      own_offset = '0;
      if (q_v_ff && q_col_ok_ff) begin
         total      = tot_rd_ff;
         region     = reg_rd_ff;
         row_offset = q_row_ok_ff ? ofs_row_rd_ff : span_end;
         own_offset = q_own_ok_ff ? ofs_own_rd_ff : span_end;
      end
   end

endmodule
